### rtl/core/dlq_pkg.sv
package dlq_pkg;

    localparam int DLQ_POOL_NODES = 64;

    localparam int OP_W     = 2;
    localparam int NODE_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0]   node_out;
        logic                node_valid;
        logic [COUNT_W-1:0]  queue_count;
        logic [STATUS_W-1:0] status;
    } t_rsp;

endpackage

### rtl/core/dlq_if.sv
interface dlq_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [dlq_pkg::OP_W-1:0]      operation;
    logic [dlq_pkg::NODE_W-1:0]    node_index;

    modport source (output valid, output operation, output node_index, input ready);
    modport sink   (input valid, input operation, input node_index, output ready);
endinterface

interface dlq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dlq_pkg::NODE_W-1:0]    node_out;
    logic                          node_valid;
    logic [dlq_pkg::COUNT_W-1:0]   queue_count;
    logic [dlq_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output node_out, output node_valid,
                    output queue_count, output status, input ready);
    modport sink   (input valid, input node_out, input node_valid,
                    input queue_count, input status, output ready);
endinterface

### rtl/core/dlq_ram.sv
module dlq_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = dlq_pkg::DLQ_POOL_NODES
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/dlq_result_reg.sv
module dlq_result_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dlq_pkg::t_rsp     i_rsp,
    output logic              o_free,
    dlq_rsp_if.source         o_rsp
);

    logic          r_valid;
    dlq_pkg::t_rsp r_rsp;

    // slot can take a new item when empty or being drained this cycle
    assign o_free = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.node_out    = r_rsp.node_out;
    assign o_rsp.node_valid  = r_rsp.node_valid;
    assign o_rsp.queue_count = r_rsp.queue_count;
    assign o_rsp.status      = r_rsp.status;

endmodule

### rtl/core/doubly_linked_queue_manager_unit.sv
// Flow: a command accept starts the memory read; the execute state then decides,
//   writes back and loads the output register, waiting while that register is full.
// Commands are not taken while one is in progress; a remove or dequeue of a non-tail
//   entry adds an unmark state, since the membership table has a single write port.
// Reset: synchronous, active low; afterwards a clearing pass over all POOL_NODES
//   entries wipes the membership bits while the command side is not ready.
module doubly_linked_queue_manager_unit #(
    parameter int POOL_NODES = dlq_pkg::DLQ_POOL_NODES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dlq_cmd_if.sink   i_cmd,
    dlq_rsp_if.source o_rsp
);

    localparam int AW = $clog2(POOL_NODES);       // handle / link width
    localparam int CW = $clog2(POOL_NODES + 1);   // entry count width
    localparam int PW = AW + 1;                    // {member, prev link}

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_EXEC   = 2'd2;
    localparam logic [1:0] ST_UNMARK = 2'd3;

    logic [1:0] r_state, n_state;
    logic [AW-1:0] r_clr_addr;

    // captured command
    logic [dlq_pkg::OP_W-1:0]   r_op;
    logic [dlq_pkg::NODE_W-1:0] r_node;
    logic [AW-1:0]              r_addr;

    // list registers
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    // memory ports
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [PW-1:0] prev_rd;
    logic [AW-1:0] next_rd;
    logic          prev_wr_en, next_wr_en;
    logic [AW-1:0] prev_wr_addr, next_wr_addr;
    logic [PW-1:0] prev_wr_data;
    logic [AW-1:0] next_wr_data;

    // execute-stage decode
    logic          in_range, member, before_ok, after_ok, go, unmark_later;
    logic          out_free, out_load;
    logic [AW-1:0] prev_h, next_h;
    dlq_pkg::t_rsp rsp;

    logic accept;

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // dequeue reads the head entry, everything else the named handle
    assign rd_en   = accept;
    assign rd_addr = (i_cmd.operation == dlq_pkg::OP_DEQUEUE) ? r_head
                                                              : AW'(i_cmd.node_index);

    // prev memory also holds the membership bit in its top position
    dlq_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prev_wr_en),
        .i_wr_addr (prev_wr_addr),
        .i_wr_data (prev_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (prev_rd)
    );

    dlq_ram #(.WIDTH(AW), .DEPTH(POOL_NODES)) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_wr_en),
        .i_wr_addr (next_wr_addr),
        .i_wr_data (next_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (next_rd)
    );

    dlq_result_reg u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_rsp   (rsp),
        .o_free  (out_free),
        .o_rsp   (o_rsp)
    );

    assign in_range  = 32'(r_node) < 32'(POOL_NODES);
    assign member    = prev_rd[PW-1];
    assign prev_h    = prev_rd[AW-1:0];
    assign next_h    = next_rd;
    // links of the head's prev and the tail's next are never relied on:
    // position in the list is known from the head and tail registers
    assign before_ok = (r_addr != r_head);
    assign after_ok  = (r_addr != r_tail);
    assign go        = (r_state == ST_EXEC) && out_free;
    assign out_load  = go;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        prev_wr_en   = 1'b0;
        prev_wr_addr = r_addr;
        prev_wr_data = '0;
        next_wr_en   = 1'b0;
        next_wr_addr = r_tail;
        next_wr_data = r_addr;
        unmark_later = 1'b0;
        rsp          = '0;
        rsp.status   = dlq_pkg::STAT_OK;

        unique case (r_state)
            ST_CLEAR: begin
                // wipe membership, one entry a cycle
                prev_wr_en   = 1'b1;
                prev_wr_addr = r_clr_addr;
                if (r_clr_addr == AW'(POOL_NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                priority if (r_op == dlq_pkg::OP_ENQUEUE) begin
                    if (!in_range) begin
                        rsp.status = dlq_pkg::STAT_ABSENT;
                    end else if (member) begin
                        rsp.status = dlq_pkg::STAT_DUP;
                    end else begin
                        // link behind the current tail
                        prev_wr_en   = go;
                        prev_wr_data = {1'b1, r_tail};
                        next_wr_en   = go && (r_count != '0);
                        if (r_count == '0) begin
                            n_head = r_addr;
                        end
                        n_tail  = r_addr;
                        n_count = CW'(r_count + 1'b1);
                    end
                end else if ((r_op == dlq_pkg::OP_DEQUEUE && r_count == '0) ||
                             (r_op == dlq_pkg::OP_REMOVE && (!in_range || !member)) ||
                             r_op == dlq_pkg::OP_NOP) begin
                    if (r_op == dlq_pkg::OP_DEQUEUE) begin
                        rsp.status = dlq_pkg::STAT_EMPTY;
                    end else if (r_op == dlq_pkg::OP_REMOVE) begin
                        rsp.status = dlq_pkg::STAT_ABSENT;
                    end
                end else begin
                    // unlink r_addr: dequeue of the head or remove of a member
                    if (r_op == dlq_pkg::OP_DEQUEUE) begin
                        rsp.node_out   = dlq_pkg::NODE_W'(r_head);
                        rsp.node_valid = 1'b1;
                    end
                    if (before_ok) begin
                        next_wr_en   = go;
                        next_wr_addr = prev_h;
                        next_wr_data = next_h;
                    end else begin
                        n_head = after_ok ? next_h : '0;
                    end
                    if (after_ok) begin
                        // successor takes the prev port; drop membership next cycle
                        prev_wr_en   = go;
                        prev_wr_addr = next_h;
                        prev_wr_data = {1'b1, prev_h};
                        unmark_later = 1'b1;
                    end else begin
                        n_tail       = before_ok ? prev_h : '0;
                        prev_wr_en   = go;
                        prev_wr_data = '0;
                    end
                    n_count = CW'(r_count - 1'b1);
                end
                rsp.queue_count = dlq_pkg::COUNT_W'(n_count);
                if (go) begin
                    n_state = unmark_later ? ST_UNMARK : ST_IDLE;
                end else begin
                    // hold until the result slot frees up
                    n_head  = r_head;
                    n_tail  = r_tail;
                    n_count = r_count;
                end
            end
            ST_UNMARK: begin
                prev_wr_en   = 1'b1;
                prev_wr_data = '0;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // command capture, payload only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_cmd.operation;
            r_node <= i_cmd.node_index;
            r_addr <= rd_addr;
        end
    end

endmodule

### rtl/core/dlq_checker.sv
module dlq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [dlq_pkg::NODE_W-1:0]      i_node_out,
    input logic                            i_node_valid,
    input logic [dlq_pkg::COUNT_W-1:0]     i_queue_count,
    input logic [dlq_pkg::STATUS_W-1:0]    i_status
);

    // a popped handle always comes with an ok status
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_node_valid |-> i_status == dlq_pkg::STAT_OK)
        else $error("popped handle with non-ok status");

    // no handle shown unless one was popped
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_node_valid |-> i_node_out == '0)
        else $error("node_out nonzero without a pop");

    // empty report only when nothing is queued
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == dlq_pkg::STAT_EMPTY |-> i_queue_count == '0)
        else $error("empty status with nonzero count");

    // duplicate means the handle is queued, so the queue is not empty
    a_dup_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == dlq_pkg::STAT_DUP |-> i_queue_count != '0)
        else $error("duplicate status on an empty queue");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_node_out) &&
            $stable(i_queue_count) && $stable(i_status))
        else $error("stalled result changed");

endmodule

bind doubly_linked_queue_manager_unit dlq_checker u_dlq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_node_out    (o_rsp.node_out),
    .i_node_valid  (o_rsp.node_valid),
    .i_queue_count (o_rsp.queue_count),
    .i_status      (o_rsp.status)
);
